// ===== rtl/cdw_pkg.sv =====
// Shared types and constants for the command frame deframer and watchdog.
package cdw_pkg;

  // Item opcodes on the input channel.
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_IDLE = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  // Frame header bytes.
  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'h55;

  // Timeout register value after reset, in microsecond ticks.
  localparam logic [31:0] TIMEOUT_RESET = 32'd100000;

  // Watchdog controls issued by the deframer for one item.
  typedef struct packed {
    logic tick;
    logic clear;
  } wd_ctrl_t;

  // One result item as held in the output buffer.
  typedef struct packed {
    logic signed [15:0] steer_cmd;
    logic signed [15:0] speed_cmd;
    logic               link_ok;
    logic               frame_accepted;
    logic               frame_rejected;
  } result_t;

endpackage

// ===== rtl/cdw_cell.sv =====
// One byte cell of the frame shift chain.
module cdw_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // Take the neighbor's byte when the chain shifts, otherwise hold.
  always_comb begin
    byte_nxt = shift_en ? din : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign dout = byte_r;

endmodule

// ===== rtl/cdw_watchdog.sv =====
// Link watchdog: timeout register, saturating elapsed counter and good-frame flag.
module cdw_watchdog import cdw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  wd_ctrl_t    ctrl,
  output logic        link_ok_nxt
);

  logic [31:0] timeout_r;
  logic [31:0] timeout_nxt;
  logic [31:0] elapsed_r;
  logic [31:0] elapsed_nxt;
  logic        good_r;
  logic        good_nxt;

  // A good frame clears the counter; ticks count up and stop at all ones.
  always_comb begin
    timeout_nxt = cfg_wr_en ? cfg_wr_data : timeout_r;
    good_nxt    = good_r | ctrl.clear;
    elapsed_nxt = elapsed_r;
    if (ctrl.clear) begin
      elapsed_nxt = '0;
    end else if (ctrl.tick && (elapsed_r != '1)) begin
      elapsed_nxt = elapsed_r + 32'd1;
    end
  end

  // Link status as it stands after this item's update.
  assign link_ok_nxt = good_nxt && (elapsed_nxt < timeout_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      elapsed_r <= '0;
      good_r    <= 1'b0;
    end else begin
      timeout_r <= timeout_nxt;
      elapsed_r <= elapsed_nxt;
      good_r    <= good_nxt;
    end
  end

endmodule

// ===== rtl/command_frame_deframer_watchdog_top.sv =====
// Output: each result is registered into the head of the output buffer and offered
// on the output from there; a stalled result waits in the output buffer.
// Throughput: one item per cycle while the skid entry is free; a two-entry output buffer
// keeps the input open while one result waits, and the byte chain, XOR and watchdog are each registered.
// Reset: synchronous, active low; clears the byte count, XOR, latches, good flag,
// elapsed counter and output buffer, and sets the timeout to 100000 ticks.
// The frame byte cells are not reset.
module command_frame_deframer_watchdog_top import cdw_pkg::*; #(
  parameter int FRAME_LEN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_steer_cmd,
  output logic signed [15:0] out_speed_cmd,
  output logic               out_link_ok,
  output logic               out_frame_accepted,
  output logic               out_frame_rejected,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  localparam int CNT_W = $clog2(FRAME_LEN + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_LEN);
  localparam logic [CNT_W-1:0] XOR_CNT  = CNT_W'(FRAME_LEN - 1);

  opcode_t            op;
  logic               in_xfer;
  logic               out_xfer;
  logic               shift_en;
  logic               frame_ok;
  logic               link_ok_nxt;
  wd_ctrl_t           wd_ctrl;
  logic [7:0]         cell_q [FRAME_LEN];

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [7:0]         xor_r;
  logic [7:0]         xor_nxt;
  logic signed [15:0] steer_r;
  logic signed [15:0] steer_nxt;
  logic signed [15:0] speed_r;
  logic signed [15:0] speed_nxt;
  logic               accepted;
  logic               rejected;
  result_t            res_new;

  result_t            head_r;
  result_t            head_nxt;
  logic               head_valid_r;
  logic               head_valid_nxt;
  result_t            skid_r;
  result_t            skid_nxt;
  logic               skid_valid_r;
  logic               skid_valid_nxt;

  assign op       = opcode_t'(in_opcode);
  assign in_ready = !skid_valid_r;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = head_valid_r && out_ready;

  // Byte chain: a new byte enters cell 0 and the rest move one place along.
  assign shift_en = in_xfer && (op == OP_BYTE) && (count_r < FULL_CNT);

  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      cdw_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .din      (in_rx_byte),
        .dout     (cell_q[i])
      );
    end else begin : g_body
      cdw_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .din      (cell_q[i-1]),
        .dout     (cell_q[i])
      );
    end
  end

  // With a full frame, byte k sits in cell FRAME_LEN-1-k and the checksum in cell 0.
  assign frame_ok = (count_r == FULL_CNT)
                 && (cell_q[FRAME_LEN-1] == HDR0)
                 && (cell_q[FRAME_LEN-2] == HDR1)
                 && (cell_q[0] == xor_r);

  // Per-item frame control.
  always_comb begin
    count_nxt = count_r;
    xor_nxt   = xor_r;
    steer_nxt = steer_r;
    speed_nxt = speed_r;
    accepted  = 1'b0;
    rejected  = 1'b0;
    wd_ctrl   = '0;
    if (in_xfer) begin
      unique case (op)
        OP_BYTE: begin
          if (count_r < FULL_CNT) begin
            count_nxt = count_r + CNT_W'(1);
            if (count_r < XOR_CNT) begin
              xor_nxt = xor_r ^ in_rx_byte;
            end
          end
        end
        OP_IDLE: begin
          if (frame_ok) begin
            steer_nxt     = {cell_q[FRAME_LEN-4], cell_q[FRAME_LEN-3]};
            speed_nxt     = {cell_q[FRAME_LEN-6], cell_q[FRAME_LEN-5]};
            accepted      = 1'b1;
            wd_ctrl.clear = 1'b1;
          end else begin
            rejected = 1'b1;
          end
          count_nxt = '0;
          xor_nxt   = '0;
        end
        OP_TICK: begin
          wd_ctrl.tick = 1'b1;
        end
        OP_NONE: begin
        end
      endcase
    end
  end

  cdw_watchdog u_watchdog (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctrl        (wd_ctrl),
    .link_ok_nxt (link_ok_nxt)
  );

  // Result of the item being transferred in.
  always_comb begin
    res_new.steer_cmd      = steer_nxt;
    res_new.speed_cmd      = speed_nxt;
    res_new.link_ok        = link_ok_nxt;
    res_new.frame_accepted = accepted;
    res_new.frame_rejected = rejected;
  end

  // Two-entry output buffer: head drives the port, skid catches a result
  // that arrives while the head is stalled.
  always_comb begin
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_xfer) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (in_xfer) begin
        head_nxt = res_new;
      end else begin
        head_valid_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      if (head_valid_r) begin
        skid_nxt       = res_new;
        skid_valid_nxt = 1'b1;
      end else begin
        head_nxt       = res_new;
        head_valid_nxt = 1'b1;
      end
    end
  end

  // Control and latch registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      xor_r        <= '0;
      steer_r      <= '0;
      speed_r      <= '0;
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      xor_r        <= xor_nxt;
      steer_r      <= steer_nxt;
      speed_r      <= speed_nxt;
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Buffer payload.
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = head_valid_r;
  assign out_steer_cmd      = head_r.steer_cmd;
  assign out_speed_cmd      = head_r.speed_cmd;
  assign out_link_ok        = head_r.link_ok;
  assign out_frame_accepted = head_r.frame_accepted;
  assign out_frame_rejected = head_r.frame_rejected;

endmodule

// ===== rtl/cdw_checker.sv =====
// Port-level checks for the command frame deframer and watchdog.
module cdw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_steer_cmd,
  input logic signed [15:0] out_speed_cmd,
  input logic               out_link_ok,
  input logic               out_frame_accepted,
  input logic               out_frame_rejected
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_steer_cmd)
      && $stable(out_speed_cmd) && $stable(out_link_ok)
      && $stable(out_frame_accepted) && $stable(out_frame_rejected))
    else $error("stalled result changed");

  // One idle event either accepts or rejects, never both.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_accepted && out_frame_rejected))
    else $error("frame both accepted and rejected");

  // A transfer into an empty output shows up on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result missing one cycle after transfer");

  // Reset empties the output buffer and opens the input.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("buffer not empty after reset");

endmodule

bind command_frame_deframer_watchdog_top cdw_checker u_cdw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_steer_cmd      (out_steer_cmd),
  .out_speed_cmd      (out_speed_cmd),
  .out_link_ok        (out_link_ok),
  .out_frame_accepted (out_frame_accepted),
  .out_frame_rejected (out_frame_rejected)
);

// ===== verif/command_frame_deframer_watchdog_top_test.sv =====
// Self-checking testbench for the command frame deframer and link watchdog.
module command_frame_deframer_watchdog_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cdw_pkg::*;

  localparam int FRAME_LEN     = 8;
  localparam int PHASE_ITEMS   = 280;
  localparam int NUM_PHASES    = 7;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_ROWS      = 17;

  // Kinds of frame produced by the random part.
  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_HDR, FR_SHORT, FR_LONG} frame_kind_e;

  // One row of the directed part; typed rows carry the expected result.
  typedef struct packed {
    opcode_t     op;
    logic [7:0]  rx;
    logic        typed;
    logic [15:0] steer;
    logic [15:0] speed;
    logic        link;
    logic        acc;
    logic        rej;
  } stim_row_t;

  // Directed part: empty frame, unused opcode, a tick, a good frame with the steer and
  // speed extremes followed by an ignored extra byte, a tick, and a short frame.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{OP_IDLE, 8'h00, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1},
    '{OP_NONE, 8'hFF, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_TICK, 8'hA5, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'hAA, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'h55, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'hFF, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'h7F, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'h00, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'h80, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'h00, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'hFF, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'h12, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_IDLE, 8'h00, 1'b1, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b0},
    '{OP_TICK, 8'h00, 1'b1, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 1'b0},
    '{OP_BYTE, 8'hAA, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_BYTE, 8'h55, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{OP_IDLE, 8'hC3, 1'b1, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 1'b1}
  };

  // Timeout settings, one per random phase.
  logic [31:0] timeout_settings [NUM_PHASES] = '{
    32'd1, 32'hFFFF_FFFF, 32'd5, 32'd0, 32'd23, TIMEOUT_RESET, 32'd3
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = OP_BYTE;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_steer_cmd;
  logic signed [15:0] out_speed_cmd;
  logic               out_link_ok;
  logic               out_frame_accepted;
  logic               out_frame_rejected;
  logic               cfg_wr_en = 1'b0;
  logic [31:0]        cfg_wr_data = 32'h0;

  // Predicted state of the deframer and watchdog.
  logic [7:0]  frame_bytes [FRAME_LEN];
  int          frame_fill;
  logic [7:0]  frame_xor;
  logic [15:0] steer_held;
  logic [15:0] speed_held;
  logic        frame_seen;
  logic [31:0] ticks_since_frame;
  logic [31:0] link_timeout;

  result_t pending_results [$];
  int      fail_count = 0;
  int      item_count = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;
  int      stall_clock = 0;
  int      stall_mode = 0;

  command_frame_deframer_watchdog_top #(.FRAME_LEN(FRAME_LEN)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_steer_cmd     (out_steer_cmd),
    .out_speed_cmd     (out_speed_cmd),
    .out_link_ok       (out_link_ok),
    .out_frame_accepted(out_frame_accepted),
    .out_frame_rejected(out_frame_rejected),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Advances the predicted state by one item and returns its result.
  function automatic result_t deframe_step(input opcode_t op, input logic [7:0] rx);
    result_t r;
    logic    good;
    r = '0;
    case (op)
      OP_BYTE: begin
        if (frame_fill < FRAME_LEN) begin
          frame_bytes[frame_fill] = rx;
          if (frame_fill < FRAME_LEN - 1) frame_xor = frame_xor ^ rx;
          frame_fill++;
        end
      end
      OP_IDLE: begin
        good = (frame_fill == FRAME_LEN) && (frame_bytes[0] == HDR0)
               && (frame_bytes[1] == HDR1) && (frame_bytes[FRAME_LEN-1] == frame_xor);
        if (good) begin
          steer_held = {frame_bytes[3], frame_bytes[2]};
          speed_held = {frame_bytes[5], frame_bytes[4]};
          frame_seen = 1'b1;
          ticks_since_frame = '0;
          r.frame_accepted = 1'b1;
        end else begin
          r.frame_rejected = 1'b1;
        end
        frame_fill = 0;
        frame_xor = '0;
      end
      OP_TICK: begin
        if (ticks_since_frame != 32'hFFFF_FFFF) ticks_since_frame++;
      end
      default: ;
    endcase
    r.steer_cmd = steer_held;
    r.speed_cmd = speed_held;
    r.link_ok = frame_seen && (ticks_since_frame < link_timeout);
    return r;
  endfunction

  // Presents one item in bursts with random gaps and queues its result.
  task automatic send_item(input opcode_t op, input logic [7:0] rx,
                           input logic typed, input result_t want);
    result_t pred;
    int      gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_rx_byte <= rx;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    pred = deframe_step(op, rx);
    pending_results.push_back(typed ? want : pred);
    item_count++;
  endtask

  // Stops the sender until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Writes the timeout register while the block is idle.
  task automatic write_timeout(input logic [31:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    link_timeout = value;
  endtask

  // Sends one frame of the given kind, then the line-idle event.
  task automatic send_frame(input frame_kind_e kind);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] sum;
    logic [7:0] extreme [4];
    int         len;
    extreme = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    fb[0] = HDR0;
    fb[1] = HDR1;
    for (int i = 2; i < FRAME_LEN - 1; i++) begin
      fb[i] = ($urandom_range(0, 7) == 0) ? extreme[$urandom_range(0, 3)] : 8'($urandom);
    end
    if (kind == FR_BAD_HDR) begin
      fb[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum ^ fb[i];
    fb[FRAME_LEN-1] = sum;
    if (kind == FR_BAD_SUM) fb[FRAME_LEN-1] ^= 8'(1 << $urandom_range(0, 7));
    len = FRAME_LEN;
    if (kind == FR_SHORT) len = $urandom_range(0, FRAME_LEN - 1);
    if (kind == FR_LONG) len = FRAME_LEN + $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      // Ticks and unused opcodes may fall between bytes without breaking the frame.
      if ($urandom_range(0, 11) == 0) begin
        send_item(($urandom_range(0, 1) == 0) ? OP_TICK : OP_NONE, 8'($urandom), 1'b0, '0);
      end
      send_item(OP_BYTE, (i < FRAME_LEN) ? fb[i] : 8'($urandom), 1'b0, '0);
    end
    send_item(OP_IDLE, 8'($urandom), 1'b0, '0);
  endtask

  // Receiver stalls; the pattern is picked at random from four modes.
  always @(posedge clk) begin
    stall_clock <= stall_clock + 1;
    if (stall_clock % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 99) < 70);
      2:       out_ready <= (stall_clock % 4 != 3);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no expectation waiting");
      end else begin
        want = pending_results.pop_front();
        if (out_steer_cmd !== want.steer_cmd)
          report_mismatch($sformatf("steer_cmd got %0d, expected %0d",
                                    out_steer_cmd, want.steer_cmd));
        if (out_speed_cmd !== want.speed_cmd)
          report_mismatch($sformatf("speed_cmd got %0d, expected %0d",
                                    out_speed_cmd, want.speed_cmd));
        if (out_link_ok !== want.link_ok)
          report_mismatch($sformatf("link_ok got %b, expected %b",
                                    out_link_ok, want.link_ok));
        if (out_frame_accepted !== want.frame_accepted)
          report_mismatch($sformatf("frame_accepted got %b, expected %b",
                                    out_frame_accepted, want.frame_accepted));
        if (out_frame_rejected !== want.frame_rejected)
          report_mismatch($sformatf("frame_rejected got %b, expected %b",
                                    out_frame_rejected, want.frame_rejected));
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Main sequence: reset, directed rows, then random phases under each timeout.
  initial begin
    result_t row_want;
    int      pick;
    for (int i = 0; i < FRAME_LEN; i++) frame_bytes[i] = '0;
    frame_fill = 0;
    frame_xor = '0;
    steer_held = '0;
    speed_held = '0;
    frame_seen = 1'b0;
    ticks_since_frame = '0;
    link_timeout = TIMEOUT_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      row_want = '0;
      row_want.steer_cmd      = directed_rows[i].steer;
      row_want.speed_cmd      = directed_rows[i].speed;
      row_want.link_ok        = directed_rows[i].link;
      row_want.frame_accepted = directed_rows[i].acc;
      row_want.frame_rejected = directed_rows[i].rej;
      send_item(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].typed, row_want);
    end

    item_count = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_timeout(timeout_settings[p]);
      while (item_count < (p + 1) * PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_frame(FR_GOOD);
        end else if (pick < 60) begin
          send_frame(FR_BAD_SUM);
        end else if (pick < 67) begin
          send_frame(FR_BAD_HDR);
        end else if (pick < 75) begin
          send_frame(FR_SHORT);
        end else if (pick < 81) begin
          send_frame(FR_LONG);
        end else if (pick < 93) begin
          repeat ($urandom_range(1, 30)) send_item(OP_TICK, 8'($urandom), 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
          end
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
